// ===== design/assert_macros.svh =====
// Assertion helpers shared by the RTL in this folder.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clk edge, off while reset is asserted.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that an antecedent implies a consequent in the same cycle.
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== design/dadd_pkg.sv =====
// Shared constants and month-length lookup for the Gregorian date unit.
// No dependencies.
`timescale 1ns / 1ps

package dadd_pkg;

    // Day counts of the Gregorian cycles
    localparam logic [23:0] DAYS_400Y  = 24'd146097;
    localparam logic [23:0] DAYS_100Y  = 24'd36524;
    localparam logic [23:0] DAYS_4Y    = 24'd1461;
    localparam logic [23:0] DAYS_1Y    = 24'd365;
    // Day index of 9999-12-31, counted from 0001-01-01
    localparam logic [23:0] DAYS_LAST  = 24'd3652058;

    localparam logic [13:0] YEAR_MAX   = 14'd9999;
    localparam logic [3:0]  MONTH_MAX  = 4'd12;
    localparam logic [3:0]  MONTH_FEB  = 4'd2;

    // Remainder counter values that mark a century and a 400-year year
    localparam logic [4:0]  Q4_LAST    = 5'd24;
    localparam logic [1:0]  Q_LAST     = 2'd3;

    // Length of month m; leap selects 29 for February
    function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        begin
            case (m)
                4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
                4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
                MONTH_FEB:                                  len = leap ? 5'd29 : 5'd28;
                default:                                    len = 5'd0;
            endcase
            return len;
        end
    endfunction

endpackage

// ===== design/date_add_days_and_difference_core.sv =====
// Gregorian date unit: date plus signed day offset, or difference of two dates.
// Depends on dadd_pkg and assert_macros.svh.
`timescale 1ns / 1ps

// One item is in flight at a time; in_ready is high only while the sequencer
// is idle. How long an item takes depends on its data, plus any wait on
// out_ready. Each date is turned into a day index by peeling 400/100/4/1-year
// blocks (up to 24 + 3 + 24 + 3 steps) and then walking its months (up to
// 12). In add mode the clamped index is turned back into a date the same way.
// All day arithmetic runs through one 24-bit add/subtract/compare unit, with a
// small year adder beside it; those loops set the latency. A finished result
// sits in the output register until taken, and the next item is accepted as
// soon as the result has been loaded there. An illegal date gives bad_date
// with all other fields zero; an add result outside years 1..9999 saturates
// and raises year_overflow.
module date_add_days_and_difference_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        func,
    input  logic [13:0] start_year,
    input  logic [3:0]  start_month,
    input  logic [4:0]  start_day,
    input  logic [22:0] offset_days,
    input  logic [13:0] second_year,
    input  logic [3:0]  second_month,
    input  logic [4:0]  second_day,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [13:0] out_year,
    output logic [3:0]  out_month,
    output logic [4:0]  out_day,
    output logic [22:0] day_difference,
    output logic        bad_date,
    output logic        year_overflow
);

    import dadd_pkg::*;

    // Sequencer states
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CHK   = 4'd1;
    localparam logic [3:0] S_FY400 = 4'd2;
    localparam logic [3:0] S_FY100 = 4'd3;
    localparam logic [3:0] S_FY4   = 4'd4;
    localparam logic [3:0] S_FY1   = 4'd5;
    localparam logic [3:0] S_FMON  = 4'd6;
    localparam logic [3:0] S_ADD   = 4'd7;
    localparam logic [3:0] S_CLAMP = 4'd8;
    localparam logic [3:0] S_I400  = 4'd9;
    localparam logic [3:0] S_I100  = 4'd10;
    localparam logic [3:0] S_I4    = 4'd11;
    localparam logic [3:0] S_I1    = 4'd12;
    localparam logic [3:0] S_IMON  = 4'd13;
    localparam logic [3:0] S_DIFF  = 4'd14;
    localparam logic [3:0] S_DONE  = 4'd15;

    logic [3:0]  state_reg, state_next;

    // Captured item
    logic        func_reg, func_next;
    logic [13:0] y1_reg, y1_next, y2_reg, y2_next;
    logic [3:0]  m1_reg, m1_next, m2_reg, m2_next;
    logic [4:0]  d1_reg, d1_next, d2_reg, d2_next;
    logic [22:0] off_reg, off_next;

    // Working registers
    logic        sel_reg, sel_next;      // 0 first date, 1 second date
    logic [23:0] acc_reg, acc_next;      // day index / remainder / difference
    logic [21:0] idx1_reg, idx1_next;    // day index of the first date
    logic [13:0] yr_reg, yr_next;        // year remainder or rebuilt year
    logic [1:0]  q100_reg, q100_next;
    logic [4:0]  q4_reg, q4_next;
    logic [1:0]  q1_reg, q1_next;
    logic [3:0]  mon_reg, mon_next;
    logic        bad_reg, bad_next;
    logic        ovf_reg, ovf_next;

    // Output register
    logic        out_valid_reg, out_valid_next;
    logic [13:0] out_year_reg, out_year_next;
    logic [3:0]  out_month_reg, out_month_next;
    logic [4:0]  out_day_reg, out_day_next;
    logic [22:0] out_diff_reg, out_diff_next;
    logic        out_bad_reg, out_bad_next;
    logic        out_ovf_reg, out_ovf_next;

    // Shared day adder
    logic [23:0] add_a, add_b, add_res;
    logic        add_sub, add_ge;

    // Year adder
    logic [13:0] y_step;
    logic        y_sub;
    logic [14:0] y_res;
    logic        y_ge;

    // Current date and its properties
    logic [13:0] cur_y;
    logic [3:0]  cur_m;
    logic [4:0]  cur_d;
    logic        leap;
    logic [4:0]  mon_len;
    logic [4:0]  cur_len;

    assign cur_y = sel_reg ? y2_reg : y1_reg;
    assign cur_m = sel_reg ? m2_reg : m1_reg;
    assign cur_d = sel_reg ? d2_reg : d1_reg;

    // Leap from the year remainder counters: p = y - 1 with p mod 400 split
    // into q100*100 + q4*4 + q1; divisible by 4 when q1 is 3, century when
    // q4 is 24 too, 400-year when q100 is 3 as well.
    assign leap    = (q1_reg == Q_LAST) && ((q4_reg != Q4_LAST) || (q100_reg == Q_LAST));
    assign mon_len = month_days(mon_reg, leap);
    assign cur_len = month_days(cur_m, leap);

    // Operand select for the shared units
    always_comb
    begin
        add_b   = 24'd0;
        add_sub = 1'b1;
        y_step  = 14'd1;
        y_sub   = 1'b0;
        case (state_reg)
            S_FY400:
            begin
                add_b = DAYS_400Y; add_sub = 1'b0; y_step = 14'd400; y_sub = 1'b1;
            end
            S_FY100:
            begin
                add_b = DAYS_100Y; add_sub = 1'b0; y_step = 14'd100; y_sub = 1'b1;
            end
            S_FY4:
            begin
                add_b = DAYS_4Y;   add_sub = 1'b0; y_step = 14'd4;   y_sub = 1'b1;
            end
            S_FY1:
            begin
                add_b = DAYS_1Y;   add_sub = 1'b0; y_step = 14'd1;   y_sub = 1'b1;
            end
            S_FMON:
            begin
                add_sub = 1'b0;
                if (mon_reg != cur_m)
                    add_b = {19'd0, mon_len};
                else
                    add_b = {19'd0, cur_d - 5'd1};
            end
            S_ADD:
            begin
                add_b = {off_reg[22], off_reg}; add_sub = 1'b0;
            end
            S_CLAMP: add_b = DAYS_LAST + 24'd1;
            S_I400:  begin add_b = DAYS_400Y; y_step = 14'd400; end
            S_I100:  begin add_b = DAYS_100Y; y_step = 14'd100; end
            S_I4:    begin add_b = DAYS_4Y;   y_step = 14'd4;   end
            S_I1:    begin add_b = DAYS_1Y;   y_step = 14'd1;   end
            S_IMON:  add_b = {19'd0, mon_len};
            S_DIFF:  add_b = acc_reg;
            default: add_b = 24'd0;
        endcase
    end

    assign add_a   = (state_reg == S_DIFF) ? {2'd0, idx1_reg} : acc_reg;
    assign add_res = add_a + (add_sub ? ~add_b : add_b) + {23'd0, add_sub};
    assign add_ge  = ~add_res[23];

    assign y_res = y_sub ? ({1'b0, yr_reg} - {1'b0, y_step})
                         : ({1'b0, yr_reg} + {1'b0, y_step});
    assign y_ge  = ~y_res[14];

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        func_next      = func_reg;
        y1_next        = y1_reg;
        m1_next        = m1_reg;
        d1_next        = d1_reg;
        y2_next        = y2_reg;
        m2_next        = m2_reg;
        d2_next        = d2_reg;
        off_next       = off_reg;
        sel_next       = sel_reg;
        acc_next       = acc_reg;
        idx1_next      = idx1_reg;
        yr_next        = yr_reg;
        q100_next      = q100_reg;
        q4_next        = q4_reg;
        q1_next        = q1_reg;
        mon_next       = mon_reg;
        bad_next       = bad_reg;
        ovf_next       = ovf_reg;
        out_valid_next = out_valid_reg;
        out_year_next  = out_year_reg;
        out_month_next = out_month_reg;
        out_day_next   = out_day_reg;
        out_diff_next  = out_diff_reg;
        out_bad_next   = out_bad_reg;
        out_ovf_next   = out_ovf_reg;

        // result transfer
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    func_next  = func;
                    y1_next    = start_year;
                    m1_next    = start_month;
                    d1_next    = start_day;
                    off_next   = offset_days;
                    y2_next    = second_year;
                    m2_next    = second_month;
                    d2_next    = second_day;
                    sel_next   = 1'b0;
                    bad_next   = 1'b0;
                    ovf_next   = 1'b0;
                    state_next = S_CHK;
                end
            end
            // year and month range of the selected date
            S_CHK:
            begin
                if (cur_y == 14'd0 || cur_y > YEAR_MAX || cur_m == 4'd0 || cur_m > MONTH_MAX)
                begin
                    bad_next   = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    yr_next    = cur_y - 14'd1;
                    acc_next   = 24'd0;
                    q100_next  = 2'd0;
                    q4_next    = 5'd0;
                    q1_next    = 2'd0;
                    state_next = S_FY400;
                end
            end
            // peel year blocks off y - 1, summing their days
            S_FY400:
            begin
                if (y_ge)
                begin
                    yr_next  = y_res[13:0];
                    acc_next = add_res;
                end
                else
                    state_next = S_FY100;
            end
            S_FY100:
            begin
                if (y_ge)
                begin
                    yr_next   = y_res[13:0];
                    acc_next  = add_res;
                    q100_next = q100_reg + 2'd1;
                end
                else
                    state_next = S_FY4;
            end
            S_FY4:
            begin
                if (y_ge)
                begin
                    yr_next  = y_res[13:0];
                    acc_next = add_res;
                    q4_next  = q4_reg + 5'd1;
                end
                else
                    state_next = S_FY1;
            end
            S_FY1:
            begin
                if (y_ge)
                begin
                    yr_next  = y_res[13:0];
                    acc_next = add_res;
                    q1_next  = q1_reg + 2'd1;
                end
                else if (cur_d == 5'd0 || cur_d > cur_len)
                begin
                    bad_next   = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    mon_next   = 4'd1;
                    state_next = S_FMON;
                end
            end
            // add earlier months, then day - 1
            S_FMON:
            begin
                acc_next = add_res;
                if (mon_reg != cur_m)
                    mon_next = mon_reg + 4'd1;
                else if (!func_reg)
                    state_next = S_ADD;
                else if (!sel_reg)
                begin
                    idx1_next  = add_res[21:0];
                    sel_next   = 1'b1;
                    state_next = S_CHK;
                end
                else
                    state_next = S_DIFF;
            end
            S_ADD:
            begin
                acc_next   = add_res;
                state_next = S_CLAMP;
            end
            // saturate to the supported day range
            S_CLAMP:
            begin
                if (acc_reg[23])
                begin
                    acc_next = 24'd0;
                    ovf_next = 1'b1;
                end
                else if (add_ge)
                begin
                    acc_next = DAYS_LAST;
                    ovf_next = 1'b1;
                end
                yr_next    = 14'd1;
                q100_next  = 2'd0;
                q4_next    = 5'd0;
                q1_next    = 2'd0;
                state_next = S_I400;
            end
            // rebuild the year from the day index
            S_I400:
            begin
                if (add_ge)
                begin
                    acc_next = add_res;
                    yr_next  = y_res[13:0];
                end
                else
                    state_next = S_I100;
            end
            S_I100:
            begin
                if (q100_reg != Q_LAST && add_ge)
                begin
                    acc_next  = add_res;
                    yr_next   = y_res[13:0];
                    q100_next = q100_reg + 2'd1;
                end
                else
                    state_next = S_I4;
            end
            S_I4:
            begin
                if (add_ge)
                begin
                    acc_next = add_res;
                    yr_next  = y_res[13:0];
                    q4_next  = q4_reg + 5'd1;
                end
                else
                    state_next = S_I1;
            end
            S_I1:
            begin
                if (q1_reg != Q_LAST && add_ge)
                begin
                    acc_next = add_res;
                    yr_next  = y_res[13:0];
                    q1_next  = q1_reg + 2'd1;
                end
                else
                begin
                    mon_next   = 4'd1;
                    state_next = S_IMON;
                end
            end
            // walk months of the rebuilt year
            S_IMON:
            begin
                if (mon_reg != MONTH_MAX && add_ge)
                begin
                    acc_next = add_res;
                    mon_next = mon_reg + 4'd1;
                end
                else
                    state_next = S_DONE;
            end
            S_DIFF:
            begin
                acc_next   = add_res;
                state_next = S_DONE;
            end
            // load the output register once it is free
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_bad_next   = bad_reg;
                    if (bad_reg || func_reg)
                    begin
                        out_year_next  = 14'd0;
                        out_month_next = 4'd0;
                        out_day_next   = 5'd0;
                        out_ovf_next   = 1'b0;
                    end
                    else
                    begin
                        out_year_next  = yr_reg;
                        out_month_next = mon_reg;
                        out_day_next   = acc_reg[4:0] + 5'd1;
                        out_ovf_next   = ovf_reg;
                    end
                    out_diff_next  = (bad_reg || !func_reg) ? 23'd0 : acc_reg[22:0];
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        func_reg      <= func_next;
        y1_reg        <= y1_next;
        m1_reg        <= m1_next;
        d1_reg        <= d1_next;
        y2_reg        <= y2_next;
        m2_reg        <= m2_next;
        d2_reg        <= d2_next;
        off_reg       <= off_next;
        sel_reg       <= sel_next;
        acc_reg       <= acc_next;
        idx1_reg      <= idx1_next;
        yr_reg        <= yr_next;
        q100_reg      <= q100_next;
        q4_reg        <= q4_next;
        q1_reg        <= q1_next;
        mon_reg       <= mon_next;
        bad_reg       <= bad_next;
        ovf_reg       <= ovf_next;
        out_year_reg  <= out_year_next;
        out_month_reg <= out_month_next;
        out_day_reg   <= out_day_next;
        out_diff_reg  <= out_diff_next;
        out_bad_reg   <= out_bad_next;
        out_ovf_reg   <= out_ovf_next;
    end

    assign in_ready       = (state_reg == S_IDLE);
    assign out_valid      = out_valid_reg;
    assign out_year       = out_year_reg;
    assign out_month      = out_month_reg;
    assign out_day        = out_day_reg;
    assign day_difference = out_diff_reg;
    assign bad_date       = out_bad_reg;
    assign year_overflow  = out_ovf_reg;

`include "assert_macros.svh"

    // A rejected date carries no other result
    `ASSERT_IMPL(a_bad_clears, out_valid && bad_date,
        out_year == 14'd0 && day_difference == 23'd0 && !year_overflow, "bad_date with data")
    // Saturation lands on one of the two range ends
    `ASSERT_IMPL(a_sat_ends, out_valid && !bad_date && year_overflow,
        (out_year == 14'd1 && out_month == 4'd1 && out_day == 5'd1) ||
        (out_year == YEAR_MAX && out_month == MONTH_MAX && out_day == 5'd31),
        "overflow result not saturated")
    // 4-year counter stays inside one 100-year block
    `ASSERT_IMPL(a_q4_range, state_reg == S_FY1 || state_reg == S_I1,
        q4_reg <= Q4_LAST, "4-year counter out of range")
    // Month walk stays within the year
    `ASSERT_IMPL(a_mon_range, state_reg == S_IMON || state_reg == S_FMON,
        mon_reg >= 4'd1 && mon_reg <= MONTH_MAX, "month walk out of range")
    // An accepted item starts the sequencer on its date check
    `ASSERT_CLK(a_take_idle, (in_valid && in_ready) |=> state_reg == S_CHK,
        "accepted item did not start")

endmodule

// ===== verif/date_add_days_and_difference_core_tb.sv =====
// Self-checking testbench for date_add_days_and_difference_core: directed calendar
// corner cases, then random add and difference requests under random idling.
// Depends only on the RTL; expected results come from a calendar model kept here.
`timescale 1ns / 1ps

module date_add_days_and_difference_core_tb;

    // Operation codes carried on func
    localparam logic FUNC_ADD  = 1'b0;
    localparam logic FUNC_DIFF = 1'b1;

    // Calendar constants, counted in days from 0001-01-01
    localparam int DAYS_PER_400Y  = 146097;
    localparam int DAYS_PER_100Y  = 36524;
    localparam int DAYS_PER_4Y    = 1461;
    localparam int DAYS_PER_YEAR  = 365;
    localparam int LAST_DAY_INDEX = 3652058;    // 9999-12-31

    localparam int unsigned STALL_LIMIT  = 5000;
    localparam int unsigned DRAIN_CYCLES = 200;
    localparam int unsigned RANDOM_ITEMS = 600;

    typedef struct {
        logic        func;
        logic [13:0] year1;
        logic [3:0]  month1;
        logic [4:0]  day1;
        logic [22:0] offset;
        logic [13:0] year2;
        logic [3:0]  month2;
        logic [4:0]  day2;
    } date_request_t;

    typedef struct {
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [22:0] diff;
        logic        bad;
        logic        sat;
    } date_result_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic        func;
    logic [13:0] start_year;
    logic [3:0]  start_month;
    logic [4:0]  start_day;
    logic [22:0] offset_days;
    logic [13:0] second_year;
    logic [3:0]  second_month;
    logic [4:0]  second_day;
    logic        out_valid;
    logic        out_ready;
    logic [13:0] out_year;
    logic [3:0]  out_month;
    logic [4:0]  out_day;
    logic [22:0] day_difference;
    logic        bad_date;
    logic        year_overflow;

    // Set by the stimulus thread for stretches with no idling on either side
    bit steady;
    int unsigned idle_cycles;

    date_add_days_and_difference_core uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .func           (func),
        .start_year     (start_year),
        .start_month    (start_month),
        .start_day      (start_day),
        .offset_days    (offset_days),
        .second_year    (second_year),
        .second_month   (second_month),
        .second_day     (second_day),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_year       (out_year),
        .out_month      (out_month),
        .out_day        (out_day),
        .day_difference (day_difference),
        .bad_date       (bad_date),
        .year_overflow  (year_overflow)
    );

    // ------------------------------------------------------------------
    // Calendar arithmetic
    // ------------------------------------------------------------------

    function automatic bit leap_year(input int unsigned y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    // Only February depends on the leap rule
    function automatic int unsigned month_length(input int unsigned y, input int unsigned m);
        int unsigned len;
        case (m)
            1, 3, 5, 7, 8, 10, 12: len = 31;
            4, 6, 9, 11:           len = 30;
            2:                     len = leap_year(y) ? 29 : 28;
            default:               len = 0;
        endcase
        return len;
    endfunction

    function automatic bit legal_date(input int unsigned y, input int unsigned m,
                                      input int unsigned d);
        if (y < 1 || y > 9999 || m < 1 || m > 12)
            return 1'b0;
        return d >= 1 && d <= month_length(y, m);
    endfunction

    // Day number of a legal date, 0001-01-01 being day 0
    function automatic int day_number(input int unsigned y, input int unsigned m,
                                      input int unsigned d);
        int unsigned p;
        int n;
        p = y - 1;
        n = p * 365 + p / 4 - p / 100 + p / 400;
        for (int unsigned k = 1; k < m; k++)
            n += month_length(y, k);
        return n + d - 1;
    endfunction

    // Peel 400/100/4/1-year blocks, then walk the months of the final year
    function automatic void day_number_to_date(input int unsigned n, output int unsigned y,
                                               output int unsigned m, output int unsigned d);
        int unsigned q400, q100, q4, q1, r, len;
        q400 = n / DAYS_PER_400Y;
        r    = n % DAYS_PER_400Y;
        q100 = r / DAYS_PER_100Y;
        if (q100 > 3)
            q100 = 3;
        r -= q100 * DAYS_PER_100Y;
        q4 = r / DAYS_PER_4Y;
        r  = r % DAYS_PER_4Y;
        q1 = r / DAYS_PER_YEAR;
        if (q1 > 3)
            q1 = 3;
        r -= q1 * DAYS_PER_YEAR;
        y   = q400 * 400 + q100 * 100 + q4 * 4 + q1 + 1;
        m   = 1;
        len = month_length(y, m);
        while (m < 12 && r >= len) begin
            r -= len;
            m++;
            len = month_length(y, m);
        end
        d = r + 1;
    endfunction

    function automatic date_result_t predict_date_result(input date_request_t rq);
        date_result_t r;
        int n, off;
        int unsigned y, m, d;
        r = '{default: '0};
        if (rq.func == FUNC_ADD) begin
            if (!legal_date(rq.year1, rq.month1, rq.day1)) begin
                r.bad = 1'b1;
            end else begin
                off = $signed(rq.offset);
                n = day_number(rq.year1, rq.month1, rq.day1) + off;
                // Saturate at either end of years 1..9999
                if (n < 0) begin
                    n = 0;
                    r.sat = 1'b1;
                end else if (n > LAST_DAY_INDEX) begin
                    n = LAST_DAY_INDEX;
                    r.sat = 1'b1;
                end
                day_number_to_date(n, y, m, d);
                r.year  = y[13:0];
                r.month = m[3:0];
                r.day   = d[4:0];
            end
        end else begin
            if (!legal_date(rq.year1, rq.month1, rq.day1) ||
                !legal_date(rq.year2, rq.month2, rq.day2)) begin
                r.bad = 1'b1;
            end else begin
                n = day_number(rq.year1, rq.month1, rq.day1)
                  - day_number(rq.year2, rq.month2, rq.day2);
                r.diff = n[22:0];
            end
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Scoreboard: one expected result per accepted request, in order
    // ------------------------------------------------------------------

    class date_scoreboard;
        date_result_t pending_results[$];
        int unsigned  n_errors;
        int unsigned  n_checked;
        int unsigned  n_add;
        int unsigned  n_diff;
        int unsigned  n_bad;
        int unsigned  n_sat;

        function void note_request(input date_request_t rq);
            date_result_t r;
            r = predict_date_result(rq);
            if (rq.func == FUNC_ADD)
                n_add++;
            else
                n_diff++;
            if (r.bad)
                n_bad++;
            if (r.sat)
                n_sat++;
            pending_results.push_back(r);
        endfunction

        function void check_field(input string name, input logic [22:0] want,
                                  input logic [22:0] got);
            if (got !== want) begin
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
                n_errors++;
            end
        endfunction

        function void check_result(input date_result_t got);
            date_result_t want;
            if (pending_results.size() == 0) begin
                $error("result transfer with no request outstanding");
                n_errors++;
                return;
            end
            want = pending_results.pop_front();
            n_checked++;
            check_field("out_year",       want.year,  got.year);
            check_field("out_month",      want.month, got.month);
            check_field("out_day",        want.day,   got.day);
            check_field("day_difference", want.diff,  got.diff);
            check_field("bad_date",       want.bad,   got.bad);
            check_field("year_overflow",  want.sat,   got.sat);
        endfunction
    endclass

    date_scoreboard sb;

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic date_request_t make_request(
        input logic fn, input int unsigned y1, input int unsigned m1, input int unsigned d1,
        input int off, input int unsigned y2, input int unsigned m2, input int unsigned d2);
        date_request_t rq;
        rq.func   = fn;
        rq.year1  = y1[13:0];
        rq.month1 = m1[3:0];
        rq.day1   = d1[4:0];
        rq.offset = off[22:0];
        rq.year2  = y2[13:0];
        rq.month2 = m2[3:0];
        rq.day2   = d2[4:0];
        return rq;
    endfunction

    // Legal date, leaning toward century years, both ends and month ends
    function automatic void pick_date(output logic [13:0] y, output logic [3:0] m,
                                      output logic [4:0] d);
        int unsigned yy, mm, len;
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 7))
                    0: yy = 4;
                    1: yy = 100;
                    2: yy = 400;
                    3: yy = 1600;
                    4: yy = 1700;
                    5: yy = 1900;
                    6: yy = 2000;
                    default: yy = 2100;
                endcase
            end
            1: yy = $urandom_range(1, 12);
            2: yy = $urandom_range(9988, 9999);
            default: yy = $urandom_range(1, 9999);
        endcase
        mm  = $urandom_range(1, 12);
        len = month_length(yy, mm);
        y = yy[13:0];
        m = mm[3:0];
        d = ($urandom_range(0, 4) == 0) ? len[4:0] : 5'($urandom_range(1, len));
    endfunction

    function automatic date_request_t random_request();
        date_request_t rq;
        int off, target;
        int unsigned y, m, d, pick;
        rq.func = ($urandom_range(0, 1) == 1) ? FUNC_DIFF : FUNC_ADD;
        pick_date(rq.year1, rq.month1, rq.day1);
        pick_date(rq.year2, rq.month2, rq.day2);

        // Offset: mostly short or medium hops, some huge, some landing near either end
        case ($urandom_range(0, 9))
            0, 1, 2: off = int'($urandom_range(0, 800)) - 400;
            3, 4, 5: off = int'($urandom_range(0, 80000)) - 40000;
            6, 7:    off = int'($urandom_range(0, 2 * LAST_DAY_INDEX)) - LAST_DAY_INDEX;
            8:       off = $signed(23'($urandom()));
            default: begin
                if ($urandom_range(0, 1) == 0)
                    target = int'($urandom_range(0, 6)) - 3;
                else
                    target = LAST_DAY_INDEX - 3 + int'($urandom_range(0, 6));
                off = target - day_number(rq.year1, rq.month1, rq.day1);
            end
        endcase
        rq.offset = off[22:0];

        // Difference between nearby dates now and then
        if (rq.func == FUNC_DIFF && $urandom_range(0, 3) == 0) begin
            target = day_number(rq.year1, rq.month1, rq.day1) + int'($urandom_range(0, 800))
                   - 400;
            if (target < 0)
                target = 0;
            if (target > LAST_DAY_INDEX)
                target = LAST_DAY_INDEX;
            day_number_to_date(target, y, m, d);
            rq.year2  = y[13:0];
            rq.month2 = m[3:0];
            rq.day2   = d[4:0];
        end

        // Raw field values for either date, mostly illegal
        pick = $urandom_range(0, 99);
        if (pick < 6) begin
            rq.year1  = 14'($urandom_range(0, 16383));
            rq.month1 = 4'($urandom_range(0, 15));
            rq.day1   = 5'($urandom_range(0, 31));
        end else if (pick < 10) begin
            rq.year2  = 14'($urandom_range(0, 16383));
            rq.month2 = 4'($urandom_range(0, 15));
            rq.day2   = 5'($urandom_range(0, 31));
        end
        return rq;
    endfunction

    // Optional gap, then hold the request until it transfers
    task automatic send_request(input date_request_t rq);
        int unsigned gap;
        gap = steady ? 0 : $urandom_range(0, 5);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        func         <= rq.func;
        start_year   <= rq.year1;
        start_month  <= rq.month1;
        start_day    <= rq.day1;
        offset_days  <= rq.offset;
        second_year  <= rq.year2;
        second_month <= rq.month2;
        second_day   <= rq.day2;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Result side: random stalls, some before the result shows, some after
    // ------------------------------------------------------------------

    initial begin : result_sink
        int unsigned stall;
        bit late;
        out_ready = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever begin
            stall = steady ? 0 : $urandom_range(0, 5);
            late  = ($urandom_range(0, 1) == 1);
            if (stall == 0) begin
                out_ready <= 1'b1;
            end else begin
                out_ready <= 1'b0;
                if (late) begin
                    @(posedge clk);
                    while (!out_valid)
                        @(posedge clk);
                end
                repeat (stall) @(posedge clk);
                out_ready <= 1'b1;
            end
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    // ------------------------------------------------------------------
    // Transfer monitor and watchdog
    // ------------------------------------------------------------------

    always @(posedge clk) begin : monitor
        date_request_t seen_rq;
        date_result_t  seen_rs;
        if (rst_n) begin
            if (in_valid && in_ready) begin
                seen_rq.func   = func;
                seen_rq.year1  = start_year;
                seen_rq.month1 = start_month;
                seen_rq.day1   = start_day;
                seen_rq.offset = offset_days;
                seen_rq.year2  = second_year;
                seen_rq.month2 = second_month;
                seen_rq.day2   = second_day;
                sb.note_request(seen_rq);
            end
            if (out_valid && out_ready) begin
                seen_rs.year  = out_year;
                seen_rs.month = out_month;
                seen_rs.day   = out_day;
                seen_rs.diff  = day_difference;
                seen_rs.bad   = bad_date;
                seen_rs.sat   = year_overflow;
                sb.check_result(seen_rs);
            end
            // Nothing moving for too long means the block is hung
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("Timeout: no transfer in %0d cycles", STALL_LIMIT);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial begin : main_seq
        date_request_t directed_q[$];
        sb           = new();
        steady       = 1'b0;
        idle_cycles  = 0;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        func         = FUNC_ADD;
        start_year   = '0;
        start_month  = '0;
        start_day    = '0;
        offset_days  = '0;
        second_year  = '0;
        second_month = '0;
        second_day   = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed corners: both ends of the calendar, offset extremes, leap rule
        directed_q.push_back(make_request(FUNC_ADD, 1, 1, 1, 0, 16383, 15, 31));
        directed_q.push_back(make_request(FUNC_ADD, 1, 1, 1, -1, 0, 0, 0));
        directed_q.push_back(make_request(FUNC_ADD, 9999, 12, 31, 1, 1, 1, 1));
        directed_q.push_back(make_request(FUNC_ADD, 9999, 12, 31, -LAST_DAY_INDEX, 1, 1, 1));
        directed_q.push_back(make_request(FUNC_ADD, 1, 1, 1, 4194303, 1, 1, 1));
        directed_q.push_back(make_request(FUNC_ADD, 5000, 6, 15, -4194304, 1, 1, 1));
        directed_q.push_back(make_request(FUNC_ADD, 2000, 2, 28, 1, 1, 1, 1));
        directed_q.push_back(make_request(FUNC_ADD, 1900, 2, 28, 1, 1, 1, 1));
        directed_q.push_back(make_request(FUNC_ADD, 2004, 2, 29, 365, 1, 1, 1));
        directed_q.push_back(make_request(FUNC_ADD, 2024, 12, 31, 1, 1, 1, 1));
        directed_q.push_back(make_request(FUNC_ADD, 2024, 1, 1, -1, 1, 1, 1));
        // Illegal first dates in add mode
        directed_q.push_back(make_request(FUNC_ADD, 1900, 2, 29, 5, 1, 1, 1));
        directed_q.push_back(make_request(FUNC_ADD, 2023, 4, 31, 5, 1, 1, 1));
        directed_q.push_back(make_request(FUNC_ADD, 2023, 0, 10, 5, 1, 1, 1));
        directed_q.push_back(make_request(FUNC_ADD, 2023, 5, 0, 5, 1, 1, 1));
        directed_q.push_back(make_request(FUNC_ADD, 16383, 15, 31, -1, 1, 1, 1));
        directed_q.push_back(make_request(FUNC_ADD, 0, 1, 1, 0, 1, 1, 1));
        directed_q.push_back(make_request(FUNC_ADD, 10000, 1, 1, 0, 1, 1, 1));
        // Differences: widest spans, equal dates, leap and century Februaries, illegal
        directed_q.push_back(make_request(FUNC_DIFF, 9999, 12, 31, -1, 1, 1, 1));
        directed_q.push_back(make_request(FUNC_DIFF, 1, 1, 1, 0, 9999, 12, 31));
        directed_q.push_back(make_request(FUNC_DIFF, 1234, 7, 19, 0, 1234, 7, 19));
        directed_q.push_back(make_request(FUNC_DIFF, 2000, 3, 1, 0, 2000, 2, 28));
        directed_q.push_back(make_request(FUNC_DIFF, 2100, 3, 1, 0, 2100, 2, 28));
        directed_q.push_back(make_request(FUNC_DIFF, 2020, 5, 5, 0, 2020, 13, 5));
        directed_q.push_back(make_request(FUNC_DIFF, 2020, 5, 0, 0, 2020, 5, 5));
        foreach (directed_q[i])
            send_request(directed_q[i]);

        // Random requests, with a stretch of back-to-back traffic in the middle
        for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
            steady = (i >= 250 && i < 350);
            send_request(random_request());
        end
        in_valid <= 1'b0;
        steady = 1'b0;

        // Drain, then watch a while for stray results
        while (sb.pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Checked %0d results: %0d date additions, %0d differences.",
                 sb.n_checked, sb.n_add, sb.n_diff);
        $display("Of these %0d had an illegal date and %0d saturated the year.",
                 sb.n_bad, sb.n_sat);
        if (sb.n_errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
